FILE: sv/rpcc_pkg.sv
`default_nettype none

package rpcc_pkg;

	// Width of one color channel and of every result field.
	localparam int PixW = 8;

	// Floor division by three: floor(s / 3) == (s * 683) >> 11 for every s up to 765.
	localparam int SumW      = PixW + 2;
	localparam int GrayProdW = 20;
	localparam int GrayMul   = 683;
	localparam int GrayShift = 11;

	// The scaled numerator 255 * (max - channel) spans two channel widths.
	localparam int NumW     = 2 * PixW;
	// One quotient bit is resolved per divider stage.
	localparam int DivSteps = PixW;
	localparam int StepW    = $clog2(DivSteps);

	// Number of CMY lanes.
	localparam int Lanes = 3;

	// Results that are final after the first stages and only ride along.
	typedef struct packed {
		logic [PixW-1:0] gray_level;
		logic [PixW-1:0] opp_red;
		logic [PixW-1:0] opp_green;
		logic [PixW-1:0] opp_blue;
		logic [PixW-1:0] opp_yellow;
		logic [PixW-1:0] key_black;
	} side_t;

	// State of the three CMY dividers at one stage. Only the low numerator half
	// travels down the divider; the high half seeds the remainder at entry.
	typedef struct packed {
		logic [Lanes-1:0][PixW-1:0] rem;
		logic [Lanes-1:0][PixW-1:0] quo;
		logic [Lanes-1:0][PixW-1:0] num;
		logic [PixW-1:0]            mx;
		side_t                      side;
	} div_stage_t;

endpackage

`default_nettype wire

FILE: sv/rpcc_pix_if.sv
`default_nettype none

interface rpcc_pix_if;
	import rpcc_pkg::*;

	logic            valid;
	logic            ready;
	logic [PixW-1:0] red;
	logic [PixW-1:0] green;
	logic [PixW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: sv/rpcc_res_if.sv
`default_nettype none

interface rpcc_res_if;
	import rpcc_pkg::*;

	logic            valid;
	logic            ready;
	logic [PixW-1:0] gray_level;
	logic [PixW-1:0] opp_red;
	logic [PixW-1:0] opp_green;
	logic [PixW-1:0] opp_blue;
	logic [PixW-1:0] opp_yellow;
	logic [PixW-1:0] key_black;
	logic [PixW-1:0] cyan_level;
	logic [PixW-1:0] magenta_level;
	logic [PixW-1:0] yellow_level;

	modport source (
		output valid, output gray_level, output opp_red, output opp_green,
		output opp_blue, output opp_yellow, output key_black, output cyan_level,
		output magenta_level, output yellow_level, input ready
	);
	modport sink (
		input valid, input gray_level, input opp_red, input opp_green,
		input opp_blue, input opp_yellow, input key_black, input cyan_level,
		input magenta_level, input yellow_level, output ready
	);
endinterface

`default_nettype wire

FILE: sv/rgb_pixel_color_converter.sv
// The pipeline is two arithmetic stages followed by an eight-stage restoring divider
// that resolves one CMY quotient bit per stage.
// Throughput: one pixel per cycle; the whole pipeline advances when its last stage
// is empty or its result is taken, so a stall holds every stage in place.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
`default_nettype none

module rgb_pixel_color_converter (
	input  wire        clk,
	input  wire        arst_n,
	rpcc_pix_if.sink   pix,
	rpcc_res_if.source res
);
	import rpcc_pkg::*;

	// Opponent value: max(0, floor(own - (a + b) / 2)) done on doubled values.
	function automatic logic [PixW-1:0] opp_of(
		input logic [PixW-1:0] own,
		input logic [PixW-1:0] a,
		input logic [PixW-1:0] b
	);
		logic [PixW:0] twice;
		logic [PixW:0] sum;
		logic [PixW:0] diff;
		twice = {own, 1'b0};
		sum   = {1'b0, a} + {1'b0, b};
		diff  = twice - sum;
		if (twice <= sum) begin
			return '0;
		end
		return diff[PixW:1];
	endfunction

	// One restoring division step for all lanes, consuming numerator bit idx.
	function automatic div_stage_t div_step(input div_stage_t st, input logic [StepW-1:0] idx);
		div_stage_t    nx;
		logic [PixW:0] trial;
		nx = st;
		for (int i = 0; i < Lanes; i++) begin
			trial = {st.rem[i], st.num[i][idx]};
			if (trial >= {1'b0, st.mx}) begin
				nx.rem[i] = PixW'(trial - {1'b0, st.mx});
				nx.quo[i] = {st.quo[i][PixW-2:0], 1'b1};
			end else begin
				nx.rem[i] = trial[PixW-1:0];
				nx.quo[i] = {st.quo[i][PixW-2:0], 1'b0};
			end
		end
		return nx;
	endfunction

	logic adv;

	// Stage 1 registers.
	logic            vld_s1;
	logic [PixW-1:0] red_s1, green_s1, blue_s1, mx_s1;
	side_t           side_s1;
	logic [SumW-1:0] sum_s1;

	// Stage 2 registers.
	logic                       vld_s2;
	logic [PixW-1:0]            mx_s2;
	logic [Lanes-1:0][NumW-1:0] num_s2;
	side_t                      side_s2;

	// Stage 2 combinational terms.
	side_t side_gray_c;

	// Divider stages.
	logic       [DivSteps-1:0] div_vld_s;
	div_stage_t                div_s [DivSteps];
	div_stage_t                div_in [DivSteps];

	// Stage 1 combinational terms.
	logic [PixW-1:0] mx_c, mn_rg_c;
	logic [SumW-1:0] sum_c;
	side_t           side_c;

	// The pipeline moves as a whole whenever the output slot is free or being taken.
	assign adv       = !div_vld_s[DivSteps-1] || res.ready;
	assign pix.ready = adv;

	// Maximum, sum, opponent values and key black of the incoming pixel.
	always_comb begin
		mx_c = pix.red;
		if (pix.green > mx_c) begin
			mx_c = pix.green;
		end
		if (pix.blue > mx_c) begin
			mx_c = pix.blue;
		end
		mn_rg_c = (pix.red < pix.green) ? pix.red : pix.green;
		sum_c   = SumW'(pix.red) + SumW'(pix.green) + SumW'(pix.blue);

		side_c            = '0;
		side_c.opp_red    = opp_of(pix.red, pix.green, pix.blue);
		side_c.opp_green  = opp_of(pix.green, pix.red, pix.blue);
		side_c.opp_blue   = opp_of(pix.blue, pix.red, pix.green);
		side_c.opp_yellow = (mn_rg_c > pix.blue) ? PixW'(mn_rg_c - pix.blue) : '0;
		side_c.key_black  = PixW'(2**PixW - 1) - mx_c;
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix.valid;
		end
	end

	// Stage 1 data.
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			mx_s1    <= mx_c;
			side_s1  <= side_c;
			sum_s1   <= sum_c;
		end
	end

	// Gray level from the registered channel sum, merged into the side results.
	always_comb begin
		side_gray_c            = side_s1;
		side_gray_c.gray_level =
			PixW'((GrayProdW'(sum_s1) * GrayProdW'(GrayMul)) >> GrayShift);
	end

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: take the gray level and form the numerators 255 * (max - channel).
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2     <= mx_s1;
			side_s2   <= side_gray_c;
			num_s2[0] <= {PixW'(mx_s1 - red_s1), PixW'(0)} - NumW'(mx_s1 - red_s1);
			num_s2[1] <= {PixW'(mx_s1 - green_s1), PixW'(0)} - NumW'(mx_s1 - green_s1);
			num_s2[2] <= {PixW'(mx_s1 - blue_s1), PixW'(0)} - NumW'(mx_s1 - blue_s1);
		end
	end

	// Divider entry: the upper numerator half is already below max, so it seeds the remainder.
	always_comb begin
		div_in[0]      = '0;
		div_in[0].mx   = mx_s2;
		div_in[0].side = side_s2;
		for (int i = 0; i < Lanes; i++) begin
			div_in[0].num[i] = num_s2[i][PixW-1:0];
			div_in[0].rem[i] = num_s2[i][NumW-1:PixW];
		end
	end

	// Divider pipeline, one quotient bit per stage, most significant first.
	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		if (k > 0) begin : g_link
			assign div_in[k] = div_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (adv) begin
				div_vld_s[k] <= (k == 0) ? vld_s2 : div_vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_step(div_in[k], StepW'(DivSteps - 1 - k));
			end
		end
	end

	// Result fields; a black pixel gives zero CMY.
	assign res.valid         = div_vld_s[DivSteps-1];
	assign res.gray_level    = div_s[DivSteps-1].side.gray_level;
	assign res.opp_red       = div_s[DivSteps-1].side.opp_red;
	assign res.opp_green     = div_s[DivSteps-1].side.opp_green;
	assign res.opp_blue      = div_s[DivSteps-1].side.opp_blue;
	assign res.opp_yellow    = div_s[DivSteps-1].side.opp_yellow;
	assign res.key_black     = div_s[DivSteps-1].side.key_black;
	assign res.cyan_level    = (div_s[DivSteps-1].mx == '0) ? '0 : div_s[DivSteps-1].quo[0];
	assign res.magenta_level = (div_s[DivSteps-1].mx == '0) ? '0 : div_s[DivSteps-1].quo[1];
	assign res.yellow_level  = (div_s[DivSteps-1].mx == '0) ? '0 : div_s[DivSteps-1].quo[2];

endmodule

`default_nettype wire
